// File: rtl/lr_pkg.sv
// Shared widths, request codes and direction flag positions for the line rasteriser.
package lr_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 24;
    localparam int FLAG_BITS  = 3;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam int FLAG_YMAJOR = 0;
    localparam int FLAG_XNEG   = 1;
    localparam int FLAG_YNEG   = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic        [COLOR_BITS-1:0] color_t;
    typedef logic        [FLAG_BITS-1:0]  flags_t;

endpackage

// File: rtl/line_rasterizer.sv
// Bresenham line generator for all octants with a registered pixel output.
//
// Send a start word (req_type 0) with both endpoints and a colour; it yields the first
// pixel at once. Each step word (req_type 1) yields the next pixel, and the pixel at the
// second endpoint carries last_pixel. A step word with no line in progress is taken and
// gives nothing; a start word drops any line in progress. One word is taken per cycle and
// its pixel appears on the m_ channel the cycle after: the error term compare and the
// coordinate step sit between the line state registers and the output register. The output
// register is refilled in the same cycle it is drained, so s_ready only falls while a
// pixel waits on a stalled m_ side.
module line_rasterizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic signed [lr_pkg::COORD_BITS-1:0] s_start_x,
    input  logic signed [lr_pkg::COORD_BITS-1:0] s_start_y,
    input  logic signed [lr_pkg::COORD_BITS-1:0] s_end_x,
    input  logic signed [lr_pkg::COORD_BITS-1:0] s_end_y,
    input  logic        [lr_pkg::COLOR_BITS-1:0] s_line_color,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [lr_pkg::COORD_BITS-1:0] m_pixel_x,
    output logic signed [lr_pkg::COORD_BITS-1:0] m_pixel_y,
    output logic        [lr_pkg::COLOR_BITS-1:0] m_pixel_color,
    output logic                            m_last_pixel
);
    import lr_pkg::*;

    logic   busy_reg,       busy_next;
    coord_t cur_x_reg,      cur_x_next;
    coord_t cur_y_reg,      cur_y_next;
    err_t   err_reg,        err_next;
    delta_t major_reg,      major_next;
    delta_t minor_reg,      minor_next;
    delta_t steps_reg,      steps_next;
    flags_t flags_reg,      flags_next;
    color_t color_reg,      color_next;

    logic   m_valid_reg,    m_valid_next;
    coord_t px_reg,         px_next;
    coord_t py_reg,         py_next;
    color_t pcolor_reg,     pcolor_next;
    logic   plast_reg,      plast_next;

    logic                    accept;
    logic                    emit;
    logic signed [COORD_BITS:0] dx_fwd, dx_bwd, dy_fwd, dy_bwd;
    logic                    x_neg, y_neg, y_major;
    delta_t                  dx_abs, dy_abs, maj_new, min_new;
    err_t                    err_init, err_diag, err_straight;
    logic                    move_minor;
    coord_t                  x_adv, y_adv;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        dx_fwd = {s_end_x[COORD_BITS-1], s_end_x} - {s_start_x[COORD_BITS-1], s_start_x};
        dx_bwd = {s_start_x[COORD_BITS-1], s_start_x} - {s_end_x[COORD_BITS-1], s_end_x};
        dy_fwd = {s_end_y[COORD_BITS-1], s_end_y} - {s_start_y[COORD_BITS-1], s_start_y};
        dy_bwd = {s_start_y[COORD_BITS-1], s_start_y} - {s_end_y[COORD_BITS-1], s_end_y};
        x_neg   = s_end_x < s_start_x;
        y_neg   = s_end_y < s_start_y;
        dx_abs  = x_neg ? dx_bwd[COORD_BITS-1:0] : dx_fwd[COORD_BITS-1:0];
        dy_abs  = y_neg ? dy_bwd[COORD_BITS-1:0] : dy_fwd[COORD_BITS-1:0];
        y_major = dy_abs > dx_abs;
        maj_new = y_major ? dy_abs : dx_abs;
        min_new = y_major ? dx_abs : dy_abs;
        err_init = $signed({1'b0, min_new, 1'b0}) - $signed({2'b00, maj_new});

        move_minor   = err_reg > 0;
        err_straight = err_reg + $signed({1'b0, minor_reg, 1'b0});
        err_diag     = err_reg + ($signed({1'b0, minor_reg, 1'b0})
                                - $signed({1'b0, major_reg, 1'b0}));
        x_adv = flags_reg[FLAG_XNEG] ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
        y_adv = flags_reg[FLAG_YNEG] ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);

        busy_next  = busy_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        err_next   = err_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        steps_next = steps_reg;
        flags_next = flags_reg;
        color_next = color_reg;
        emit       = 1'b0;
        plast_next = plast_reg;

        if (accept) begin
            case (s_req_type)
                REQ_START: begin
                    emit       = 1'b1;
                    cur_x_next = s_start_x;
                    cur_y_next = s_start_y;
                    major_next = maj_new;
                    minor_next = min_new;
                    steps_next = maj_new;
                    err_next   = err_init;
                    flags_next = '0;
                    flags_next[FLAG_YMAJOR] = y_major;
                    flags_next[FLAG_XNEG]   = x_neg;
                    flags_next[FLAG_YNEG]   = y_neg;
                    color_next = s_line_color;
                    busy_next  = maj_new != '0;
                    plast_next = maj_new == '0;
                end
                REQ_STEP: begin
                    if (busy_reg) begin
                        emit     = 1'b1;
                        err_next = move_minor ? err_diag : err_straight;
                        if (flags_reg[FLAG_YMAJOR]) begin
                            cur_y_next = y_adv;
                            if (move_minor) begin
                                cur_x_next = x_adv;
                            end
                        end else begin
                            cur_x_next = x_adv;
                            if (move_minor) begin
                                cur_y_next = y_adv;
                            end
                        end
                        steps_next = steps_reg - COORD_BITS'(1);
                        busy_next  = steps_reg != COORD_BITS'(1);
                        plast_next = steps_reg == COORD_BITS'(1);
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        px_next     = emit ? cur_x_next : px_reg;
        py_next     = emit ? cur_y_next : py_reg;
        pcolor_next = emit ? color_next : pcolor_reg;

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            err_reg     <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
            steps_reg   <= '0;
            flags_reg   <= '0;
            color_reg   <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            err_reg     <= err_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            steps_reg   <= steps_next;
            flags_reg   <= flags_next;
            color_reg   <= color_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        pcolor_reg <= pcolor_next;
        plast_reg  <= plast_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = pcolor_reg;
    assign m_last_pixel  = plast_reg;

endmodule

// File: verif/tb_line_rasterizer.sv
// Self-checking testbench for the all-octant Bresenham line rasteriser.
`timescale 1ns / 1ps

module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    localparam coord_t CRD_LO  = coord_t'(COORD_MIN);
    localparam coord_t CRD_HI  = coord_t'(COORD_MAX);

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    logic   aclk = 1'b0;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    logic   s_req_type;
    coord_t s_start_x;
    coord_t s_start_y;
    coord_t s_end_x;
    coord_t s_end_y;
    color_t s_line_color;
    logic   m_valid;
    logic   m_ready;
    coord_t m_pixel_x;
    coord_t m_pixel_y;
    color_t m_pixel_color;
    logic   m_last_pixel;

    pixel_t pending_pixels[$];
    int     fail_count = 0;
    int     words_sent = 0;
    int     cycle_count = 0;
    bit     no_idle = 1'b0;

    logic   ln_busy = 1'b0;
    coord_t ln_x = '0;
    coord_t ln_y = '0;
    err_t   ln_err = '0;
    delta_t ln_major = '0;
    delta_t ln_minor = '0;
    delta_t ln_steps = '0;
    flags_t ln_flags = '0;
    color_t ln_color = '0;

    line_rasterizer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_line_color  (s_line_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Advance the line state by one word and queue the pixel it yields.
    task automatic raster_word(input logic req, input coord_t x1, input coord_t y1,
                               input coord_t x2, input coord_t y2, input color_t col);
        pixel_t px;
        int     dx;
        int     dy;
        logic   move_minor;
        if (req == REQ_START) begin
            dx = (x2 >= x1) ? int'(x2) - int'(x1) : int'(x1) - int'(x2);
            dy = (y2 >= y1) ? int'(y2) - int'(y1) : int'(y1) - int'(y2);
            ln_flags = '0;
            if (x2 < x1) ln_flags[FLAG_XNEG] = 1'b1;
            if (y2 < y1) ln_flags[FLAG_YNEG] = 1'b1;
            if (dy <= dx) begin
                ln_major = delta_t'(dx);
                ln_minor = delta_t'(dy);
            end else begin
                ln_major = delta_t'(dy);
                ln_minor = delta_t'(dx);
                ln_flags[FLAG_YMAJOR] = 1'b1;
            end
            ln_err   = err_t'(2 * int'(ln_minor) - int'(ln_major));
            ln_steps = ln_major;
            ln_x     = x1;
            ln_y     = y1;
            ln_color = col;
            ln_busy  = (ln_steps != '0);
        end else begin
            if (!ln_busy) return;
            move_minor = (ln_err > 0);
            if (move_minor) begin
                ln_err = err_t'(int'(ln_err) + 2 * (int'(ln_minor) - int'(ln_major)));
            end else begin
                ln_err = err_t'(int'(ln_err) + 2 * int'(ln_minor));
            end
            if (ln_flags[FLAG_YMAJOR] || move_minor) begin
                ln_y = ln_flags[FLAG_YNEG] ? ln_y - 1'b1 : ln_y + 1'b1;
            end
            if (!ln_flags[FLAG_YMAJOR] || move_minor) begin
                ln_x = ln_flags[FLAG_XNEG] ? ln_x - 1'b1 : ln_x + 1'b1;
            end
            ln_steps = ln_steps - 1'b1;
            ln_busy  = (ln_steps != '0);
        end
        px.x     = ln_x;
        px.y     = ln_y;
        px.color = ln_color;
        px.last  = !ln_busy;
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic coord_t rand_near(input coord_t base, input int span);
        int lo;
        int hi;
        lo = int'(base) - span;
        hi = int'(base) + span;
        if (lo < COORD_MIN) lo = COORD_MIN;
        if (hi > COORD_MAX) hi = COORD_MAX;
        return coord_t'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic send_word(input logic req, input coord_t x1, input coord_t y1,
                             input coord_t x2, input coord_t y2, input color_t col);
        int gap;
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_start_x    <= x1;
        s_start_y    <= y1;
        s_end_x      <= x2;
        s_end_y      <= y2;
        s_line_color <= col;
        do @(posedge aclk); while (!s_ready);
        raster_word(req, x1, y1, x2, y2, col);
        words_sent++;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_start(input coord_t x1, input coord_t y1, input coord_t x2,
                              input coord_t y2, input color_t col);
        send_word(REQ_START, x1, y1, x2, y2, col);
    endtask

    task automatic send_step();
        send_word(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), color_t'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // Start a random line, then walk it to the end, drop it early or overrun it.
    task automatic run_line(input int span);
        coord_t x1;
        coord_t y1;
        int     len;
        x1 = coord_t'($urandom);
        y1 = coord_t'($urandom);
        send_start(x1, y1, rand_near(x1, span), rand_near(y1, span), color_t'($urandom));
        len = int'(ln_steps);
        case ($urandom_range(0, 9))
            0: len = $urandom_range(0, len);
            1: len = len + $urandom_range(1, 3);
            default: ;
        endcase
        repeat (len) send_step();
    endtask

    task automatic test_idle_and_single();
        send_step();
        send_start(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0), 24'h000000);
        send_step();
        send_start(CRD_LO, CRD_HI, CRD_LO, CRD_HI, 24'hFFFFFF);
        send_step();
    endtask

    task automatic test_extremes_abandoned();
        send_start(CRD_LO, CRD_LO, CRD_HI, CRD_HI, 24'hA5A5A5);
        repeat (3) send_step();
        send_start(CRD_HI, CRD_HI, CRD_LO, CRD_LO, 24'h5A5A5A);
        repeat (2) send_step();
        send_start(CRD_HI, CRD_LO, CRD_LO, CRD_HI, 24'h0F0F0F);
        send_step();
        send_start(coord_t'(0), CRD_HI, coord_t'(5), CRD_LO, 24'hF0F0F0);
        repeat (3) send_step();
    endtask

    task automatic test_short_lines_complete();
        send_start(coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(-2), 24'h123456);
        repeat (4) send_step();
        send_start(coord_t'(-1), coord_t'(-1), coord_t'(-3), coord_t'(4), 24'h654321);
        repeat (6) send_step();
    endtask

    task automatic test_random_lines(input int word_count);
        int target;
        int pick;
        target = words_sent + word_count;
        while (words_sent < target) begin
            no_idle = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 49);
            if (pick < 5) begin
                send_word(logic'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), color_t'($urandom));
            end else if (pick == 5) begin
                run_line(400);
            end else if (pick < 12) begin
                run_line(40);
            end else begin
                run_line(10);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            repeat (4) run_line(10);
            wait_drained();
        end
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        repeat (20) run_line(12);
        no_idle = 1'b0;
    endtask

    task automatic test_long_line();
        no_idle = 1'b1;
        send_start(CRD_HI, CRD_LO, coord_t'(COORD_MAX - 180), coord_t'(COORD_MIN + 70),
                   24'h00FF00);
        repeat (int'(ln_steps)) send_step();
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel with nothing expected: x %0d y %0d", m_pixel_x, m_pixel_y);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, got %0d", want.x, m_pixel_x);
                    fail_count++;
                end
                if (m_pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, got %0d", want.y, m_pixel_y);
                    fail_count++;
                end
                if (m_pixel_color !== want.color) begin
                    $error("pixel_color: expected %06h, got %06h", want.color, m_pixel_color);
                    fail_count++;
                end
                if (m_last_pixel !== want.last) begin
                    $error("last_pixel: expected %0b, got %0b", want.last, m_last_pixel);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        m_ready <= 1'b1;
        forever begin
            do @(posedge aclk); while (!(m_valid && m_ready));
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_STEP;
        s_start_x    <= '0;
        s_start_y    <= '0;
        s_end_x      <= '0;
        s_end_y      <= '0;
        s_line_color <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_and_single();
        test_extremes_abandoned();
        test_short_lines_complete();
        test_random_lines(850);
        test_drain_pause();
        test_full_rate();
        test_random_lines(300);
        test_long_line();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && pending_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lr_pkg.sv
rtl/line_rasterizer.sv
verif/tb_line_rasterizer.sv
